@@ sv/fvw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvw_pkg
// Shared types and constants of the force vector to wheel setpoint mixer:
// item layouts, status codes, register indexes, and controller commands.
// ----------------------------------------------------------------------------
package fvw_pkg;

  // Default generics of the mixer.
  localparam int FRACTION_BITS_DEF = 14;
  localparam int SETPOINT_BITS_DEF = 16;

  // Fixed field widths.
  localparam int FORCE_W    = 16;
  localparam int OUT_W      = 16;
  localparam int SCALE_W    = 14;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 14;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_MOTION_ENABLE  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT_SCALE = 1'd1;

  // Register values after reset.
  localparam logic [SCALE_W-1:0] SCALE_RESET = 14'd100;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DISABLED = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
  } force_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] left_setpoint;
    logic signed [OUT_W-1:0] right_setpoint;
    logic                    left_write;
    logic                    right_write;
    status_t                 status;
  } setpoint_item_t;

  // Operations issued to the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_XX,
    MUL_YY,
    MUL_RL,
    MUL_RR,
    MUL_LHH,
    MUL_LHL,
    MUL_LLL,
    MUL_RHH,
    MUL_RHL,
    MUL_RLL
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_NUM,
    ST_SCL,
    ST_SCR,
    ST_LHH,
    ST_LHL,
    ST_LLL,
    ST_RHH,
    ST_RHL,
    ST_RLL,
    ST_DRAIN,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic    accept;
    mul_op_t mul_op;
    logic    search_init;
    logic    search_step;
    logic    load_out;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic err;
  } stat_t;

endpackage

@@ sv/fvw_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvw_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface fvw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/fvw_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvw_ctrl
// Sequencer of the mixer: steps the shared multiplier through squares,
// scaling and squared partial products, then runs the bit search; an error status skips both.
// ----------------------------------------------------------------------------
module fvw_ctrl #(
  parameter int SETPOINT_BITS = fvw_pkg::SETPOINT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output fvw_pkg::cmd_t cmd,
  input  fvw_pkg::stat_t stat
);
  import fvw_pkg::*;

  localparam int CNT_W = $clog2(SETPOINT_BITS - 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SETPOINT_BITS - 2);

  state_t           state, state_next;
  logic [CNT_W-1:0] step_cnt, step_cnt_next;
  logic             out_valid_next;
  logic             accept;
  logic             slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_SQX;
      ST_SQX:    state_next = stat.err ? ST_FINISH : ST_SQY;
      ST_SQY:    state_next = ST_NUM;
      ST_NUM:    state_next = ST_SCL;
      ST_SCL:    state_next = ST_SCR;
      ST_SCR:    state_next = ST_LHH;
      ST_LHH:    state_next = ST_LHL;
      ST_LHL:    state_next = ST_LLL;
      ST_LLL:    state_next = ST_RHH;
      ST_RHH:    state_next = ST_RHL;
      ST_RHL:    state_next = ST_RLL;
      ST_RLL:    state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_SEARCH;
      ST_SEARCH: if (step_cnt == LAST_STEP) state_next = ST_FINISH;
      ST_FINISH: if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '{accept: 1'b0, mul_op: MUL_NONE, search_init: 1'b0,
            search_step: 1'b0, load_out: 1'b0};
    case (state)
      ST_IDLE:   cmd.accept = accept;
      ST_SQX:    cmd.mul_op = stat.err ? MUL_NONE : MUL_XX;
      ST_SQY:    cmd.mul_op = MUL_YY;
      ST_SCL: begin
        cmd.mul_op      = MUL_RL;
        cmd.search_init = 1'b1;
      end
      ST_SCR:    cmd.mul_op = MUL_RR;
      ST_LHH:    cmd.mul_op = MUL_LHH;
      ST_LHL:    cmd.mul_op = MUL_LHL;
      ST_LLL:    cmd.mul_op = MUL_LLL;
      ST_RHH:    cmd.mul_op = MUL_RHH;
      ST_RHL:    cmd.mul_op = MUL_RHL;
      ST_RLL:    cmd.mul_op = MUL_RLL;
      ST_SEARCH: cmd.search_step = 1'b1;
      ST_FINISH: cmd.load_out = slot_free;
      default:   cmd.mul_op = MUL_NONE;
    endcase
  end

  // Search step counter and output valid flag.
  always_comb begin
    step_cnt_next = (state == ST_SEARCH) ? step_cnt + 1'b1 : '0;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ sv/fvw_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvw_datapath
// Input latch, configuration registers, shared multiplier, squared-scale
// accumulators, two bit-search lanes, held setpoints and output register.
// ----------------------------------------------------------------------------
module fvw_datapath #(
  parameter int FRACTION_BITS = fvw_pkg::FRACTION_BITS_DEF,
  parameter int SETPOINT_BITS = fvw_pkg::SETPOINT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  fvw_pkg::cmd_t                      cmd,
  output fvw_pkg::stat_t                     stat,
  input  fvw_pkg::force_item_t               in_item,
  output fvw_pkg::setpoint_item_t            out_item,
  input  logic                               cfg_write,
  input  logic [fvw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fvw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fvw_pkg::*;

  localparam int F    = FRACTION_BITS;
  localparam int SB   = SETPOINT_BITS;
  localparam int MW   = F + 1;          // component magnitude
  localparam int SQW  = 2 * F + 1;      // square of a component
  localparam int SW   = 2 * F + 2;      // X^2 + Y^2
  localparam int NW   = 2 * F + 3;      // signed numerator
  localparam int AW   = 2 * F + 2;      // multiplier operand a
  localparam int HW   = F + 8;          // half of a scaled numerator
  localparam int BW   = HW;             // multiplier operand b
  localparam int RW   = 2 * HW;         // scaled numerator |N| * scale
  localparam int PRW  = AW + BW;        // product
  localparam int QW   = 2 * RW;         // squared scaled numerator
  localparam int RSW  = QW - 2 * F;
  localparam int PW   = 2 * SB + 2 * F;
  localparam int CW   = (PW > RSW) ? PW : RSW;
  localparam int KW   = SB - 1;
  localparam int EW   = (SB > OUT_W) ? SB : OUT_W;
  localparam logic [31:0] UNIT = 32'd1 << F;

  // Configuration.
  logic               motion_enable;
  logic [SCALE_W-1:0] setpoint_scale;

  // Latched input and derived magnitudes.
  logic signed [FORCE_W-1:0] x_q, y_q;
  logic [FORCE_W:0]          x_mag17, y_mag17;
  logic [MW-1:0]             x_mag, y_mag;
  status_t                   status_c;

  // Multiplier.
  logic [AW-1:0]  mul_a;
  logic [BW-1:0]  mul_b;
  logic [PRW-1:0] prod;
  mul_op_t        mul_op_q;

  // Captured intermediates.
  logic [SQW-1:0] x_sq;
  logic [SW-1:0]  s_q;
  logic           zero_q;
  logic [AW-1:0]  mag_q [2];
  logic           neg_q [2];
  logic [RW-1:0]  r_q   [2];
  logic [QW-1:0]  acc_q [2];

  logic [SQW-1:0] y_sq_c;
  logic [SW-1:0]  s_c;
  logic [NW-1:0]  xs_c, ys_c;
  logic [NW-1:0]  num_c [2];

  // Search lanes.
  logic [CW-1:0] p_q [2];
  logic [CW-1:0] u_q [2];
  logic [KW-1:0] k_q [2];
  logic [CW-1:0] v_q;
  logic [CW-1:0] rs_c  [2];
  logic [CW-1:0] sum_c [2];
  logic          fit_c [2];

  // Held setpoints and final values.
  logic [OUT_W-1:0] last_q [2];
  logic [OUT_W-1:0] sp_c   [2];
  logic [EW-1:0]    kx_c   [2];
  logic [EW-1:0]    sv_c   [2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      motion_enable  <= 1'b0;
      setpoint_scale <= SCALE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MOTION_ENABLE:  motion_enable  <= cfg_data[0];
        REG_SETPOINT_SCALE: setpoint_scale <= cfg_data[SCALE_W-1:0];
        default:            motion_enable  <= motion_enable;
      endcase
    end
  end

  // Input latch.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_q <= in_item.force_x;
      y_q <= in_item.force_y;
    end
  end

  // Component magnitudes and the status of the item.
  always_comb begin
    x_mag17 = x_q[FORCE_W-1] ? (17'd0 - {x_q[FORCE_W-1], x_q}) : {1'b0, x_q};
    y_mag17 = y_q[FORCE_W-1] ? (17'd0 - {y_q[FORCE_W-1], y_q}) : {1'b0, y_q};
    x_mag   = MW'(x_mag17);
    y_mag   = MW'(y_mag17);
    if (!motion_enable) begin
      status_c = STATUS_DISABLED;
    end else if ((32'(x_mag17) > UNIT) || (32'(y_mag17) > UNIT)) begin
      status_c = STATUS_RANGE;
    end else begin
      status_c = STATUS_OK;
    end
    stat.err = (status_c != STATUS_OK);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_XX: begin
        mul_a = AW'(x_mag);
        mul_b = BW'(x_mag);
      end
      MUL_YY: begin
        mul_a = AW'(y_mag);
        mul_b = BW'(y_mag);
      end
      MUL_RL: begin
        mul_a = mag_q[0];
        mul_b = BW'(setpoint_scale);
      end
      MUL_RR: begin
        mul_a = mag_q[1];
        mul_b = BW'(setpoint_scale);
      end
      MUL_LHH: begin
        mul_a = AW'(r_q[0][RW-1:HW]);
        mul_b = r_q[0][RW-1:HW];
      end
      MUL_LHL: begin
        mul_a = AW'(r_q[0][RW-1:HW]);
        mul_b = r_q[0][HW-1:0];
      end
      MUL_LLL: begin
        mul_a = AW'(r_q[0][HW-1:0]);
        mul_b = r_q[0][HW-1:0];
      end
      MUL_RHH: begin
        mul_a = AW'(r_q[1][RW-1:HW]);
        mul_b = r_q[1][RW-1:HW];
      end
      MUL_RHL: begin
        mul_a = AW'(r_q[1][RW-1:HW]);
        mul_b = r_q[1][HW-1:0];
      end
      MUL_RLL: begin
        mul_a = AW'(r_q[1][HW-1:0]);
        mul_b = r_q[1][HW-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_op_q <= MUL_NONE;
    end else begin
      mul_op_q <= cmd.mul_op;
    end
  end

  // Signed numerators X|X| - Y|Y| and X|X| + Y|Y| from the two squares.
  always_comb begin
    y_sq_c   = prod[SQW-1:0];
    s_c      = SW'(x_sq) + SW'(y_sq_c);
    xs_c     = x_q[FORCE_W-1] ? (NW'(0) - NW'(x_sq)) : NW'(x_sq);
    ys_c     = y_q[FORCE_W-1] ? (NW'(0) - NW'(y_sq_c)) : NW'(y_sq_c);
    num_c[0] = xs_c - ys_c;
    num_c[1] = xs_c + ys_c;
  end

  // Capture of each product in the cycle after it was issued.
  always_ff @(posedge clk) begin
    case (mul_op_q)
      MUL_XX: x_sq <= prod[SQW-1:0];
      MUL_YY: begin
        s_q    <= s_c;
        zero_q <= (s_c == '0);
        for (int i = 0; i < 2; i++) begin
          neg_q[i] <= num_c[i][NW-1];
          mag_q[i] <= num_c[i][NW-1] ? AW'(NW'(0) - num_c[i]) : AW'(num_c[i]);
        end
      end
      MUL_RL:  r_q[0]   <= prod[RW-1:0];
      MUL_RR:  r_q[1]   <= prod[RW-1:0];
      MUL_LHH: acc_q[0] <= QW'(prod) << RW;
      MUL_LHL: acc_q[0] <= acc_q[0] + (QW'(prod) << (HW + 1));
      MUL_LLL: acc_q[0] <= acc_q[0] + QW'(prod);
      MUL_RHH: acc_q[1] <= QW'(prod) << RW;
      MUL_RHL: acc_q[1] <= acc_q[1] + (QW'(prod) << (HW + 1));
      MUL_RLL: acc_q[1] <= acc_q[1] + QW'(prod);
      default: x_sq <= x_sq;
    endcase
  end

  // Candidate test of one search step: (k + 2^b)^2 * S against the
  // squared scaled numerator with the fraction bits dropped.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rs_c[i]  = CW'(acc_q[i] >> (2 * F));
      sum_c[i] = p_q[i] + (u_q[i] << 1) + v_q;
      fit_c[i] = (sum_c[i] <= rs_c[i]);
    end
  end

  // Search lanes. p holds k^2*S, u holds k*S*2^b, v = S*4^b.
  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      v_q <= CW'(s_q) << (2 * (SB - 2));
      for (int i = 0; i < 2; i++) begin
        p_q[i] <= '0;
        u_q[i] <= '0;
        k_q[i] <= '0;
      end
    end else if (cmd.search_step) begin
      v_q <= v_q >> 2;
      for (int i = 0; i < 2; i++) begin
        if (fit_c[i]) begin
          p_q[i] <= sum_c[i];
          u_q[i] <= (u_q[i] + v_q) >> 1;
          k_q[i] <= {k_q[i][KW-2:0], 1'b1};
        end else begin
          u_q[i] <= u_q[i] >> 1;
          k_q[i] <= {k_q[i][KW-2:0], 1'b0};
        end
      end
    end
  end

  // Signed setpoints; a zero vector gives zero on both sides.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      kx_c[i] = EW'(k_q[i]);
      sv_c[i] = neg_q[i] ? (EW'(0) - kx_c[i]) : kx_c[i];
      sp_c[i] = zero_q ? '0 : sv_c[i][OUT_W-1:0];
    end
  end

  // Held setpoints.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_q[0] <= '0;
      last_q[1] <= '0;
    end else if (cmd.load_out && (status_c == STATUS_OK)) begin
      last_q[0] <= sp_c[0];
      last_q[1] <= sp_c[1];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item.status <= status_c;
      if (status_c == STATUS_OK) begin
        out_item.left_setpoint  <= sp_c[0];
        out_item.right_setpoint <= sp_c[1];
        out_item.left_write     <= (sp_c[0] != last_q[0]);
        out_item.right_write    <= (sp_c[1] != last_q[1]);
      end else begin
        out_item.left_setpoint  <= last_q[0];
        out_item.right_setpoint <= last_q[1];
        out_item.left_write     <= 1'b0;
        out_item.right_write    <= 1'b0;
      end
    end
  end

endmodule

@@ sv/force_vector_to_wheel_setpoints_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// force_vector_to_wheel_setpoints_unit
// Differential drive mixer: turns a force vector into wheel setpoints.
// ----------------------------------------------------------------------------
// Usage:
//   force_ch carries one item (force_x, force_y) per valid/ready handshake.
//   setpoint_ch returns exactly one item per input: both held setpoints,
//   a write flag per side that changed, and a status code.
//   cfg_write/cfg_index/cfg_data set motion_enable and setpoint_scale; write
//   them only while the block is idle.
//   A result passes the multiplier sequence of squares, scaling and squared
//   partial products, then the bit search of one result bit per cycle for
//   both wheels, then the load into the output register; an error status
//   skips straight to the load.
//   The block takes one item at a time; ready is high whenever no item is
//   in work, even while a finished result waits in the output register.
//   If the receiver stalls, the result is held steady and the block waits
//   with its next result until the output register is free.
//   Reset clears the handshake state, enable goes to 0, scale to 100, and
//   both held setpoints to 0.
// ----------------------------------------------------------------------------
module force_vector_to_wheel_setpoints_unit #(
  parameter int FRACTION_BITS = fvw_pkg::FRACTION_BITS_DEF,
  parameter int SETPOINT_BITS = fvw_pkg::SETPOINT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  fvw_stream_if.sink                      force_ch,
  fvw_stream_if.source                    setpoint_ch,
  input  logic                            cfg_write,
  input  logic [fvw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fvw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fvw_pkg::*;

  cmd_t           cmd;
  stat_t          stat;
  logic           in_ready;
  logic           out_valid;
  setpoint_item_t out_item;

  assign force_ch.ready    = in_ready;
  assign setpoint_ch.valid = out_valid;
  assign setpoint_ch.data  = out_item;

  // Sequencer.
  fvw_ctrl #(
    .SETPOINT_BITS (SETPOINT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (force_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (setpoint_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Arithmetic and storage.
  fvw_datapath #(
    .FRACTION_BITS (FRACTION_BITS),
    .SETPOINT_BITS (SETPOINT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (force_ch.data),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

@@ sv/fvw_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvw_checker
// Port-level checks of the mixer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module fvw_checker (
  input logic          clk,
  input logic          rst,
  fvw_stream_if.sink   force_ch,
  fvw_stream_if.source setpoint_ch
);
  import fvw_pkg::*;

  // A result held back by the receiver stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    setpoint_ch.valid && !setpoint_ch.ready |=>
      setpoint_ch.valid && $stable(setpoint_ch.data))
    else $error("result changed while stalled");

  // A failed update never asks for a wheel write.
  a_err_no_write: assert property (@(posedge clk) disable iff (rst)
    setpoint_ch.valid && (setpoint_ch.data.status != STATUS_OK) |->
      !setpoint_ch.data.left_write && !setpoint_ch.data.right_write)
    else $error("write flag set on a failed update");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !setpoint_ch.valid)
    else $error("result valid right after reset");

  // One item at a time: the block is busy the cycle after it takes an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    force_ch.valid && force_ch.ready |=> !force_ch.ready)
    else $error("second item taken while busy");

endmodule

bind force_vector_to_wheel_setpoints_unit fvw_checker u_fvw_checker (
  .clk         (clk),
  .rst         (rst),
  .force_ch    (force_ch),
  .setpoint_ch (setpoint_ch)
);
